### rtl/triangle_vertex_normals_core_macros.svh
// Assertion helpers shared by the core; both sample on clk_i and mute during reset.
`ifndef TRIANGLE_VERTEX_NORMALS_CORE_MACROS_SVH
`define TRIANGLE_VERTEX_NORMALS_CORE_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define TVN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define TVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tvn_pkg.sv
package tvn_pkg;

  // Field widths
  localparam int unsigned POS_W = 16;
  localparam int unsigned IDX_W = 16;
  localparam int unsigned CNT_W = 24;
  localparam int unsigned NRM_W = 16;

  // Cross product datapath
  localparam int unsigned EDGE_W  = POS_W + 1;
  localparam int unsigned PROD_W  = 2 * EDGE_W;
  localparam int unsigned CROSS_W = PROD_W + 1;
  localparam int unsigned MAG_W   = PROD_W;
  localparam int unsigned SHF_W   = $clog2(MAG_W);

  // The largest scaled magnitude sits with its leading one at NORM_TOP
  localparam int unsigned SCL_W    = 30;
  localparam int unsigned NORM_TOP = SCL_W - 1;
  localparam int unsigned SQR_W    = 2 * SCL_W;
  localparam int unsigned SUM_W    = SQR_W + 2;

  // Square root and divider
  localparam int unsigned SQ_STEPS  = SUM_W / 2;
  localparam int unsigned ROOT_W    = SUM_W / 2;
  localparam int unsigned FRAC      = 14;
  localparam int unsigned QUO_W     = FRAC + 1;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned REM_W     = ROOT_W + FRAC + 1;

  localparam int unsigned CORNERS  = 3;
  localparam int unsigned LANE_LAT = 8 + SQ_STEPS + DIV_STEPS + 1;

  typedef logic [POS_W-1:0] pos_t;
  typedef pos_t [2:0] point_t;

  typedef struct packed {
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] first_z;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic signed [POS_W-1:0] second_z;
    logic signed [POS_W-1:0] third_x;
    logic signed [POS_W-1:0] third_y;
    logic signed [POS_W-1:0] third_z;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        second_index;
    logic [IDX_W-1:0]        third_index;
  } tri_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        vertex_index;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    degenerate;
    logic                    corner_last;
    logic                    mesh_done;
  } corner_out_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
    logic                    degenerate;
  } lane_res_t;

  typedef struct packed {
    logic [CORNERS-1:0][IDX_W-1:0] idx;
    logic                          done;
  } side_t;

  typedef struct packed {
    lane_res_t [CORNERS-1:0] res;
    side_t                   side;
  } merge_in_t;

  typedef logic [2:0][SCL_W-1:0] scl3_t;
  typedef logic [2:0][QUO_W-1:0] quo3_t;

endpackage

### rtl/triangle_vertex_normals_core.sv
// Per-corner unit normals of a triangle stream. Each accepted triangle gives three result
// beats, first, second and third corner, each a Q1.14 normal tagged with its vertex index;
// a corner whose edge cross product is zero gives a zero normal with degenerate set.
// Three identical lanes, one per corner, run a 55-stage pipeline (cross product,
// normalizing shift, 31-step square root, 15-step divide) and a merge register then sends
// the three corners out one beat each. Intake is limited by the single result port: the
// pipeline advances only while its last stage is empty or the merge register takes from
// it, which happens when the merge register is idle or sends its third corner. Writing
// triangle_count restarts the triangle counter; mesh_done marks the third corner of the
// triangle that reaches a nonzero count. Write the count only while the core is empty.
`include "triangle_vertex_normals_core_macros.svh"

module triangle_vertex_normals_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tvn_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tvn_pkg::tri_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tvn_pkg::corner_out_t         out_data_o
);
  import tvn_pkg::*;

  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  seen_q;
  logic [CNT_W-1:0]  seen_inc;
  logic              done_c;
  logic              en;
  logic              take;
  logic              in_fire;
  logic              vld_q [LANE_LAT];
  side_t             side_q [LANE_LAT];
  side_t             side_c;
  point_t            pts [CORNERS];
  lane_res_t [CORNERS-1:0] lane_res;
  merge_in_t         tail;
  logic              cfg_fire;
  logic              out_done;
  logic              out_degen;
  logic              nrm_zero;
  logic              nrm_in_range;

  assign cfg_ready_o = 1'b1;

  // Move the whole pipeline only when its last stage can drain
  assign en         = !vld_q[LANE_LAT-1] || take;
  assign in_ready_o = en;
  assign in_fire    = in_valid_i && en;

  // Count triangles against the configured mesh size
  assign seen_inc = seen_q + CNT_W'(1);
  assign done_c   = (count_q != '0) && (seen_inc == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      seen_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
      seen_q  <= '0;
    end else if (in_fire) begin
      seen_q <= done_c ? '0 : seen_inc;
    end
  end

  // Valid bits travel with the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LANE_LAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < LANE_LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Indices and end-of-mesh flag travel alongside
  assign side_c.idx[0] = in_data_i.first_index;
  assign side_c.idx[1] = in_data_i.second_index;
  assign side_c.idx[2] = in_data_i.third_index;
  assign side_c.done   = done_c;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_c;
      for (int k = 1; k < LANE_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign pts[0] = {in_data_i.first_z, in_data_i.first_y, in_data_i.first_x};
  assign pts[1] = {in_data_i.second_z, in_data_i.second_y, in_data_i.second_x};
  assign pts[2] = {in_data_i.third_z, in_data_i.third_y, in_data_i.third_x};

  // One lane per corner: this corner, the next, the previous
  for (genvar c = 0; c < CORNERS; c++) begin : g_lane
    tvn_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .p_i   (pts[c]),
      .q_i   (pts[(c + 1) % CORNERS]),
      .r_i   (pts[(c + 2) % CORNERS]),
      .res_o (lane_res[c])
    );
  end

  assign tail.res  = lane_res;
  assign tail.side = side_q[LANE_LAT-1];

  tvn_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tail_i       (tail),
    .tail_valid_i (vld_q[LANE_LAT-1]),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // Terms checked on each result beat
  assign cfg_fire  = cfg_valid_i && cfg_ready_o;
  assign out_done  = out_valid_o && out_data_o.mesh_done;
  assign out_degen = out_valid_o && out_data_o.degenerate;
  assign nrm_zero  = (out_data_o.normal_x == '0) && (out_data_o.normal_y == '0) &&
                     (out_data_o.normal_z == '0);
  assign nrm_in_range = (out_data_o.normal_x <= 16'sd16384) &&
                        (out_data_o.normal_x >= -16'sd16384) &&
                        (out_data_o.normal_y <= 16'sd16384) &&
                        (out_data_o.normal_y >= -16'sd16384) &&
                        (out_data_o.normal_z <= 16'sd16384) &&
                        (out_data_o.normal_z >= -16'sd16384);

  `TVN_ASSERT_NOW(a_done_on_last, out_done, out_data_o.corner_last, "mesh_done off last corner")
  `TVN_ASSERT_NOW(a_degen_zero, out_degen, nrm_zero, "degenerate corner with nonzero normal")
  `TVN_ASSERT_NOW(a_unit_range, out_valid_o, nrm_in_range, "normal component out of range")
  `TVN_ASSERT_NEXT(a_cfg_clears, cfg_fire, seen_q == '0, "count write kept the counter")

endmodule

### rtl/tvn_isqrt.sv
module tvn_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [tvn_pkg::SUM_W-1:0]   val_i,
  output logic [tvn_pkg::ROOT_W-1:0]  root_o
);
  import tvn_pkg::*;

  typedef logic [SUM_W:0] wide_t;

  logic [SUM_W-1:0] v_q [SQ_STEPS];
  wide_t            r_q [SQ_STEPS];
  logic [SUM_W-1:0] v_in [SQ_STEPS];
  wide_t            r_in [SQ_STEPS];

  // One result bit per stage, highest first
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam wide_t B = wide_t'(1) << (2 * (SQ_STEPS - 1 - k));
    wide_t trial;

    if (k == 0) begin : g_head
      assign v_in[k] = val_i;
      assign r_in[k] = '0;
    end else begin : g_body
      assign v_in[k] = v_q[k-1];
      assign r_in[k] = r_q[k-1];
    end

    assign trial = r_in[k] + B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, v_in[k]} >= trial) begin
          v_q[k] <= v_in[k] - trial[SUM_W-1:0];
          r_q[k] <= (r_in[k] >> 1) + B;
        end else begin
          v_q[k] <= v_in[k];
          r_q[k] <= r_in[k] >> 1;
        end
      end
    end
  end

  assign root_o = r_q[SQ_STEPS-1][ROOT_W-1:0];

endmodule

### rtl/tvn_div.sv
module tvn_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  tvn_pkg::scl3_t              mag_i,
  input  logic [tvn_pkg::ROOT_W-1:0]  len_i,
  output tvn_pkg::quo3_t              quo_o
);
  import tvn_pkg::*;

  typedef logic [2:0][REM_W-1:0] rem3_t;

  rem3_t             rem_q [DIV_STEPS];
  quo3_t             quo_q [DIV_STEPS];
  logic [ROOT_W-1:0] len_q [DIV_STEPS];
  rem3_t             rem_in [DIV_STEPS];
  quo3_t             quo_in [DIV_STEPS];
  logic [ROOT_W-1:0] len_in [DIV_STEPS];

  // Restoring division, one quotient bit per stage for all three components
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    localparam int unsigned BIT = DIV_STEPS - 1 - i;
    logic [REM_W-1:0] dv;

    if (i == 0) begin : g_head
      // Dividend carries half the divisor so the quotient rounds to nearest
      for (genvar c = 0; c < 3; c++) begin : g_init
        assign rem_in[i][c] = (REM_W'(mag_i[c]) << FRAC) + REM_W'(len_i >> 1);
      end
      assign quo_in[i] = '0;
      assign len_in[i] = len_i;
    end else begin : g_body
      assign rem_in[i] = rem_q[i-1];
      assign quo_in[i] = quo_q[i-1];
      assign len_in[i] = len_q[i-1];
    end

    assign dv = REM_W'(len_in[i]) << BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[i] <= len_in[i];
        for (int c = 0; c < 3; c++) begin
          if (rem_in[i][c] >= dv) begin
            rem_q[i][c] <= rem_in[i][c] - dv;
            quo_q[i][c] <= quo_in[i][c] | (QUO_W'(1) << BIT);
          end else begin
            rem_q[i][c] <= rem_in[i][c];
            quo_q[i][c] <= quo_in[i][c];
          end
        end
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

### rtl/tvn_lane.sv
module tvn_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  tvn_pkg::point_t    p_i,
  input  tvn_pkg::point_t    q_i,
  input  tvn_pkg::point_t    r_i,
  output tvn_pkg::lane_res_t res_o
);
  import tvn_pkg::*;

  localparam int unsigned FLAG_LAT = SQ_STEPS + DIV_STEPS;

  function automatic logic signed [NRM_W-1:0] signed_normal(input logic [QUO_W-1:0] q,
                                                             input logic neg,
                                                             input logic zero);
    logic signed [NRM_W-1:0] m;
    m = NRM_W'(q);
    if (zero) begin
      return '0;
    end
    return neg ? -m : m;
  endfunction

  logic signed [EDGE_W-1:0] e1_q [3];
  logic signed [EDGE_W-1:0] e2_q [3];
  logic signed [PROD_W-1:0] pr_q [6];
  logic signed [CROSS_W-1:0] cross_c [3];
  logic [CROSS_W-1:0]       abs_c [3];
  logic [MAG_W-1:0]         mag3_q [3];
  logic [2:0]               neg3_q;
  logic [MAG_W-1:0]         max_c;
  logic [MAG_W-1:0]         m4_q;
  logic [MAG_W-1:0]         mag4_q [3];
  logic [2:0]               neg4_q;
  logic [SHF_W-1:0]         pos_c;
  logic [SHF_W-1:0]         pos5_q;
  logic [MAG_W-1:0]         mag5_q [3];
  logic [2:0]               neg5_q;
  logic                     zero5_q;
  scl3_t                    sc6_q;
  logic [2:0]               neg6_q;
  logic                     zero6_q;
  logic [SQR_W-1:0]         sq7_q [3];
  scl3_t                    sc7_q;
  logic [2:0]               neg7_q;
  logic                     zero7_q;
  logic [SUM_W-1:0]         sum8_q;
  scl3_t                    sc8_q;
  logic [3:0]               flag8_q;
  scl3_t                    sc_dly_q [SQ_STEPS];
  logic [3:0]               flag_dly_q [FLAG_LAT];
  logic [ROOT_W-1:0]        len;
  quo3_t                    quo;
  logic [3:0]               flag_out;
  lane_res_t                res_q;

  // Edges leaving this corner
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= $signed({q_i[i][POS_W-1], q_i[i]}) - $signed({p_i[i][POS_W-1], p_i[i]});
        e2_q[i] <= $signed({r_i[i][POS_W-1], r_i[i]}) - $signed({p_i[i][POS_W-1], p_i[i]});
      end
    end
  end

  // Partial products of the cross product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q[0] <= e1_q[1] * e2_q[2];
      pr_q[1] <= e1_q[2] * e2_q[1];
      pr_q[2] <= e1_q[2] * e2_q[0];
      pr_q[3] <= e1_q[0] * e2_q[2];
      pr_q[4] <= e1_q[0] * e2_q[1];
      pr_q[5] <= e1_q[1] * e2_q[0];
    end
  end

  // Split cross components into sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cross_c[i] = CROSS_W'(pr_q[2*i]) - CROSS_W'(pr_q[2*i+1]);
      abs_c[i]   = cross_c[i][CROSS_W-1] ? CROSS_W'(-cross_c[i]) : CROSS_W'(cross_c[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag3_q[i] <= abs_c[i][MAG_W-1:0];
        neg3_q[i] <= cross_c[i][CROSS_W-1];
      end
    end
  end

  // Largest magnitude
  always_comb begin
    max_c = mag3_q[0];
    if (mag3_q[1] > max_c) max_c = mag3_q[1];
    if (mag3_q[2] > max_c) max_c = mag3_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m4_q   <= max_c;
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
    end
  end

  // Leading one of the largest magnitude
  always_comb begin
    pos_c = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (m4_q[b]) pos_c = SHF_W'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos5_q  <= pos_c;
      zero5_q <= (m4_q == '0);
      mag5_q  <= mag4_q;
      neg5_q  <= neg4_q;
    end
  end

  // Scale all three by a common power of two
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (pos5_q < SHF_W'(NORM_TOP)) begin
          sc6_q[i] <= SCL_W'(mag5_q[i] << (SHF_W'(NORM_TOP) - pos5_q));
        end else begin
          sc6_q[i] <= SCL_W'(mag5_q[i] >> (pos5_q - SHF_W'(NORM_TOP)));
        end
      end
      neg6_q  <= neg5_q;
      zero6_q <= zero5_q;
    end
  end

  // Squares, then their sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq7_q[i] <= SQR_W'(sc6_q[i]) * SQR_W'(sc6_q[i]);
      end
      sc7_q   <= sc6_q;
      neg7_q  <= neg6_q;
      zero7_q <= zero6_q;
      sum8_q  <= SUM_W'(sq7_q[0]) + SUM_W'(sq7_q[1]) + SUM_W'(sq7_q[2]);
      sc8_q   <= sc7_q;
      flag8_q <= {zero7_q, neg7_q};
    end
  end

  tvn_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .val_i  (sum8_q),
    .root_o (len)
  );

  // Hold magnitudes and flags alongside the root and divide
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_dly_q[0]   <= sc8_q;
      flag_dly_q[0] <= flag8_q;
      for (int k = 1; k < SQ_STEPS; k++) begin
        sc_dly_q[k] <= sc_dly_q[k-1];
      end
      for (int k = 1; k < FLAG_LAT; k++) begin
        flag_dly_q[k] <= flag_dly_q[k-1];
      end
    end
  end

  tvn_div u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .mag_i (sc_dly_q[SQ_STEPS-1]),
    .len_i (len),
    .quo_o (quo)
  );

  assign flag_out = flag_dly_q[FLAG_LAT-1];

  // Apply signs, zero out a degenerate corner
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.x          <= signed_normal(quo[0], flag_out[0], flag_out[3]);
      res_q.y          <= signed_normal(quo[1], flag_out[1], flag_out[3]);
      res_q.z          <= signed_normal(quo[2], flag_out[2], flag_out[3]);
      res_q.degenerate <= flag_out[3];
    end
  end

  assign res_o = res_q;

endmodule

### rtl/tvn_merge.sv
module tvn_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tvn_pkg::merge_in_t    tail_i,
  input  logic                  tail_valid_i,
  output logic                  take_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tvn_pkg::corner_out_t  out_data_o
);
  import tvn_pkg::*;

  typedef enum logic [1:0] {
    CORNER_FIRST,
    CORNER_SECOND,
    CORNER_THIRD
  } corner_e;

  corner_e   sel_q;
  logic      busy_q;
  merge_in_t hold_q;
  logic      fire;
  logic      load;
  lane_res_t cur;

  assign fire   = busy_q && out_ready_i;
  assign take_o = !busy_q || (fire && sel_q == CORNER_THIRD);
  assign load   = tail_valid_i && take_o;

  // Advance through the three corner beats of the held triangle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sel_q  <= CORNER_FIRST;
    end else if (load) begin
      busy_q <= 1'b1;
      sel_q  <= CORNER_FIRST;
    end else if (fire) begin
      unique case (sel_q)
        CORNER_FIRST:  sel_q  <= CORNER_SECOND;
        CORNER_SECOND: sel_q  <= CORNER_THIRD;
        CORNER_THIRD:  busy_q <= 1'b0;
        default:       sel_q  <= CORNER_FIRST;
      endcase
    end
  end

  // Capture all lanes at once
  always_ff @(posedge clk_i) begin
    if (load) begin
      hold_q <= tail_i;
    end
  end

  always_comb begin
    unique case (sel_q)
      CORNER_FIRST:  cur = hold_q.res[0];
      CORNER_SECOND: cur = hold_q.res[1];
      CORNER_THIRD:  cur = hold_q.res[2];
      default:       cur = hold_q.res[0];
    endcase
    unique case (sel_q)
      CORNER_FIRST:  out_data_o.vertex_index = hold_q.side.idx[0];
      CORNER_SECOND: out_data_o.vertex_index = hold_q.side.idx[1];
      CORNER_THIRD:  out_data_o.vertex_index = hold_q.side.idx[2];
      default:       out_data_o.vertex_index = hold_q.side.idx[0];
    endcase
    out_data_o.normal_x    = cur.x;
    out_data_o.normal_y    = cur.y;
    out_data_o.normal_z    = cur.z;
    out_data_o.degenerate  = cur.degenerate;
    out_data_o.corner_last = (sel_q == CORNER_THIRD);
    out_data_o.mesh_done   = (sel_q == CORNER_THIRD) && hold_q.side.done;
  end

  assign out_valid_o = busy_q;

endmodule

### tb/sv/triangle_vertex_normals_core_tb.sv
module triangle_vertex_normals_core_tb;
  import tvn_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  tri_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  corner_out_t out_data_o;

  triangle_vertex_normals_core DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  // Predictor state and shared bookkeeping
  logic [CNT_W-1:0] mesh_count;
  logic [CNT_W-1:0] tri_seen;
  tri_in_t pending_tris[$];
  corner_out_t expected_corners[$];
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic hold_recv;
  int unsigned hold_cycles;
  logic hold_req;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic signed [63:0] corner_x(tri_in_t t, int k);
    case (k)
      0: corner_x = 64'(t.first_x);
      1: corner_x = 64'(t.second_x);
      default: corner_x = 64'(t.third_x);
    endcase
  endfunction

  function automatic logic signed [63:0] corner_y(tri_in_t t, int k);
    case (k)
      0: corner_y = 64'(t.first_y);
      1: corner_y = 64'(t.second_y);
      default: corner_y = 64'(t.third_y);
    endcase
  endfunction

  function automatic logic signed [63:0] corner_z(tri_in_t t, int k);
    case (k)
      0: corner_z = 64'(t.first_z);
      1: corner_z = 64'(t.second_z);
      default: corner_z = 64'(t.third_z);
    endcase
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Unit normal at corner k, from edges to the next and previous corners
  function automatic corner_out_t corner_normal(tri_in_t t, int k);
    corner_out_t res;
    logic signed [63:0] e1[3];
    logic signed [63:0] e2[3];
    logic signed [63:0] c[3];
    logic [63:0] mag[3];
    logic [63:0] top;
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] n;
    int nk;
    int pk;
    nk = (k + 1) % 3;
    pk = (k + 2) % 3;
    e1[0] = corner_x(t, nk) - corner_x(t, k);
    e1[1] = corner_y(t, nk) - corner_y(t, k);
    e1[2] = corner_z(t, nk) - corner_z(t, k);
    e2[0] = corner_x(t, pk) - corner_x(t, k);
    e2[1] = corner_y(t, pk) - corner_y(t, k);
    e2[2] = corner_z(t, pk) - corner_z(t, k);
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    res = '0;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (c[i] < 0) ? -c[i] : c[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    // Bring the largest magnitude into [2^29, 2^30)
    while (top < (64'd1 << 29)) begin
      top = top << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    while (top >= (64'd1 << 30)) begin
      top = top >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      n = (mag[i] * 64'd16384 + len / 2) / len;
      if (c[i] < 0) n = -n;
      case (i)
        0: res.normal_x = n[NRM_W-1:0];
        1: res.normal_y = n[NRM_W-1:0];
        default: res.normal_z = n[NRM_W-1:0];
      endcase
    end
    return res;
  endfunction

  // Advance the triangle counter and queue the three corner results
  task automatic predict_corners(tri_in_t t);
    corner_out_t res;
    logic done;
    tri_seen = tri_seen + 1'b1;
    done = (mesh_count != 0) && (tri_seen == mesh_count);
    if (done) tri_seen = '0;
    for (int k = 0; k < 3; k++) begin
      res = corner_normal(t, k);
      res.vertex_index = (k == 0) ? t.first_index :
                         (k == 1) ? t.second_index : t.third_index;
      res.corner_last = (k == 2);
      res.mesh_done = (k == 2) && done;
      expected_corners.push_back(res);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatch_count++;
  endtask

  // Driver: offer queued triangles, idling at the current rate
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) predict_corners(in_data_i);
      if ((!in_valid_i || in_ready_o) && pending_tris.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_tris.pop_front();
      end else if (!in_valid_i || in_ready_o) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_corners.size() == 0) begin
          report_mismatch("unexpected beat", 64'(out_data_o.vertex_index), 64'(0));
        end else begin
          corner_out_t want;
          want = expected_corners.pop_front();
          if (out_data_o.vertex_index !== want.vertex_index)
            report_mismatch("vertex_index", 64'(out_data_o.vertex_index),
                            64'(want.vertex_index));
          if (out_data_o.normal_x !== want.normal_x)
            report_mismatch("normal_x", 64'(out_data_o.normal_x), 64'(want.normal_x));
          if (out_data_o.normal_y !== want.normal_y)
            report_mismatch("normal_y", 64'(out_data_o.normal_y), 64'(want.normal_y));
          if (out_data_o.normal_z !== want.normal_z)
            report_mismatch("normal_z", 64'(out_data_o.normal_z), 64'(want.normal_z));
          if (out_data_o.degenerate !== want.degenerate)
            report_mismatch("degenerate", 64'(out_data_o.degenerate),
                            64'(want.degenerate));
          if (out_data_o.corner_last !== want.corner_last)
            report_mismatch("corner_last", 64'(out_data_o.corner_last),
                            64'(want.corner_last));
          if (out_data_o.mesh_done !== want.mesh_done)
            report_mismatch("mesh_done", 64'(out_data_o.mesh_done), 64'(want.mesh_done));
        end
      end
      out_ready_i <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_recv <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_recv) begin
      if (hold_cycles >= 400) hold_recv <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else if (hold_req && hold_cycles == 0) begin
      hold_recv <= 1'b1;
    end
  end

  // Watchdog: stop when nothing moves for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic tri_in_t random_tri(int unsigned spread);
    tri_in_t t;
    logic signed [15:0] base;
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (spread < 16 && $urandom_range(3) != 0) begin
      // Local triangle: offsets from the first corner to stay in the common range; third_z is random
      base = 16'($urandom);
      t.second_x = t.first_x + 16'($signed($urandom) >>> spread);
      t.second_y = t.first_y + 16'($signed($urandom) >>> spread);
      t.second_z = t.first_z + 16'($signed($urandom) >>> spread);
      t.third_x = t.first_x + 16'($signed($urandom) >>> spread);
      t.third_y = t.first_y + 16'($signed($urandom) >>> spread);
      t.third_z = base;
    end
    return t;
  endfunction

  task automatic write_count(logic [CNT_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    mesh_count = value;
    tri_seen = '0;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_and_settle();
    while (pending_tris.size() > 0 || in_valid_i || expected_corners.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_tris.push_back(random_tri($urandom_range(15)));
  endtask

  initial begin
    tri_in_t t;
    mesh_count = '0;
    tri_seen = '0;
    mismatch_count = 0;
    send_idle_pct = 30;
    recv_idle_pct = 77;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_count(24'd3);

    // Directed: unit right triangle, degenerate, extremes
    t = '0;
    t.second_x = 16'sh0100;
    t.third_y = 16'sh0100;
    t.first_index = 16'd0;
    t.second_index = 16'hFFFF;
    t.third_index = 16'h8000;
    pending_tris.push_back(t);
    t = '0;
    pending_tris.push_back(t);
    t = '0;
    t.second_x = 16'sh0100;
    t.third_x = 16'sh0200;
    pending_tris.push_back(t);
    t = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000,
         16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'h0000, 16'h5555};
    pending_tris.push_back(t);
    t = {16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
         16'sh7FFF, 16'sh8000, 16'sh8000, 16'hAAAA, 16'hFFFF, 16'h0001};
    pending_tris.push_back(t);
    t = '0;
    t.second_x = 16'sh0001;
    t.third_y = 16'sh0001;
    pending_tris.push_back(t);
    t = '0;
    t.second_x = 16'sh8000;
    t.third_z = 16'sh7FFF;
    pending_tris.push_back(t);
    t = '0;
    t.second_y = 16'sh0003;
    t.third_z = 16'shFFFF;
    t.second_x = 16'sh0001;
    pending_tris.push_back(t);
    queue_random(10);
    drain_and_settle();

    // Sender idles lightly, receiver heavily; random count
    write_count(24'($urandom_range(1, 12)));
    queue_random(150);
    drain_and_settle();

    // Swap idling; also hold the receiver off to fill the pipeline
    send_idle_pct = 77;
    recv_idle_pct = 30;
    write_count(24'hFFFFFF);
    hold_req = 1'b1;
    queue_random(150);
    drain_and_settle();
    hold_req = 1'b0;

    // No idling; counter wrap disabled with zero count, then count one
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_count(24'd0);
    queue_random(80);
    drain_and_settle();
    write_count(24'd1);
    queue_random(80);
    drain_and_settle();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/tvn_pkg.sv
rtl/tvn_isqrt.sv
rtl/tvn_div.sv
rtl/tvn_lane.sv
rtl/tvn_merge.sv
rtl/triangle_vertex_normals_core.sv
tb/sv/triangle_vertex_normals_core_tb.sv
